@@ rtl/fhal_pkg.sv @@
// fhal_pkg: types and fixed constants for the first-fit heap allocator
// no dependencies; imported by every module of the block

package fhal_pkg;

   localparam int HEADER_BYTES      = 16;
   localparam int ALIGN_BYTES       = 16;
   localparam int MIN_PAYLOAD_BYTES = 16;
   localparam int GROW_MIN_BYTES    = 4096;
   localparam logic [31:0] LIMIT_RESET = 32'd65536;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_OOM     = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic {
      CSR_HEAP_BASE  = 1'b0,
      CSR_HEAP_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAKE,
      ST_DROP,
      ST_GROW,
      ST_PSCAN,
      ST_PDECIDE,
      ST_SHIFTUP
   } state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
   } ext_type;

   // round up to the alignment, at least the minimum payload
   function automatic logic [32:0] round_size(logic [31:0] req);
      logic [32:0] r;
      r = ({1'b0, req} + 33'(ALIGN_BYTES - 1)) & ~33'(ALIGN_BYTES - 1);
      if (r < 33'(MIN_PAYLOAD_BYTES)) r = 33'(MIN_PAYLOAD_BYTES);
      return r;
   endfunction

   // growth amount: max(size + header, grow minimum)
   function automatic logic [33:0] grow_need(logic [32:0] size);
      logic [33:0] n;
      n = {1'b0, size} + 34'(HEADER_BYTES);
      if (n < 34'(GROW_MIN_BYTES)) n = 34'(GROW_MIN_BYTES);
      return n;
   endfunction

endpackage

@@ rtl/fhal_mem.sv @@
// fhal_mem: free extent table, one write and one registered read port
// depends on fhal_pkg for the entry type

module fhal_mem
   import fhal_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  ext_type       wdata,
   input  logic [AW-1:0] raddr,
   output ext_type       rdata
);

   ext_type mem_ff [DEPTH];
   ext_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/fhal_csr.sv @@
// fhal_csr: heap_base and heap_limit registers behind the apb port
// depends on fhal_pkg for register indexes and reset values

module fhal_csr
   import fhal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] heap_base,
   output logic [31:0] heap_limit
);

   logic [31:0] base_ff;
   logic [31:0] limit_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         limit_ff <= LIMIT_RESET;
      end else if (wr_en) begin
         unique case (csr_index_type'(paddr[2]))
            CSR_HEAP_BASE:  base_ff  <= pwdata;
            CSR_HEAP_LIMIT: limit_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(paddr[2]))
         CSR_HEAP_BASE:  prdata = base_ff;
         CSR_HEAP_LIMIT: prdata = limit_ff;
         default:        prdata = '0;
      endcase
   end

   assign heap_base  = base_ff;
   assign heap_limit = limit_ff;

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// first_fit_heap_allocator_unit: sequencer over the free extent table
// depends on fhal_pkg, fhal_mem and fhal_csr
//
// Usage: pulse start with the request fields while busy is low; the transaction
// is taken at that edge and, unless it is ignored, busy rises until the result.
// Each transaction yields one result, shown for exactly one cycle with
// rsp_strobe high; the receiver cannot stall it. busy falls in the strobe cycle,
// so the next transaction may start then.
// Sequencing: an ignored request answers in the cycle after start. An allocate
// scans the table one entry per cycle; removing an entry shifts the tail down
// one entry per cycle. A growth adds a scan, an optional shift of the tail (up,
// or down when it merges on both sides) and a second scan. A free costs a scan
// and at most one shift. The extent memory, with one write and one registered
// read port, moves one entry per cycle.
// Reset: the table is empty, heap usage zero, heap_base 0, heap_limit 65536.
// No clearing pass is needed. The user must write registers over the apb port
// only while the block is idle; the block does not enforce it. They take effect on the next growth.

module first_fit_heap_allocator_unit
   import fhal_pkg::*;
#(
   parameter int MAX_EXTENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [31:0] req_size,
   input  logic [31:0] req_block_addr,
   input  logic [31:0] req_block_size,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_payload_addr,
   output logic [31:0] rsp_granted_size,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);

   logic [31:0] heap_base;
   logic [31:0] heap_limit;

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   ext_type       mem_wdata;
   logic [IW-1:0] mem_raddr;
   ext_type       mem_rdata;

   fhal_csr u_csr (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .heap_base(heap_base), .heap_limit(heap_limit)
   );

   fhal_mem #(.DEPTH(MAX_EXTENTS), .AW(IW)) u_mem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   // control
   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] used_ff, used_in;
   logic        pv_ff, pv_in;
   logic        strobe_ff, strobe_in;
   // working payload
   logic        alloc_ff, alloc_in;
   logic        retry_ff, retry_in;
   logic        put_ff, put_in;
   logic [32:0] size_ff, size_in;
   logic [31:0] st_ff, st_in;
   logic [31:0] sz_ff, sz_in;
   logic [CW-1:0] ridx_ff, ridx_in;
   logic [CW-1:0] pa_ff, pa_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic        has_next_ff, has_next_in;
   ext_type     nxt_ff, nxt_in;
   ext_type     prv_ff, prv_in;
   logic [31:0] ga_ff, ga_in;
   logic [31:0] gs_ff, gs_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] paddr_ff, paddr_in;
   logic [31:0] gsize_ff, gsize_in;

   // datapath temporaries
   logic [33:0] need;
   logic [33:0] have_need;
   logic [33:0] nx_end, nx_sum, pv_end, pv_sum, nsz;
   logic        with_next, with_prev;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         used_ff   <= '0;
         pv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         used_ff   <= used_in;
         pv_ff     <= pv_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      alloc_ff    <= alloc_in;
      retry_ff    <= retry_in;
      put_ff      <= put_in;
      size_ff     <= size_in;
      st_ff       <= st_in;
      sz_ff       <= sz_in;
      ridx_ff     <= ridx_in;
      pa_ff       <= pa_in;
      hit_ff      <= hit_in;
      has_next_ff <= has_next_in;
      nxt_ff      <= nxt_in;
      prv_ff      <= prv_in;
      ga_ff       <= ga_in;
      gs_ff       <= gs_in;
      status_ff   <= status_in;
      paddr_ff    <= paddr_in;
      gsize_ff    <= gsize_in;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      used_in     = used_ff;
      pv_in       = pv_ff;
      strobe_in   = 1'b0;
      alloc_in    = alloc_ff;
      retry_in    = retry_ff;
      put_in      = put_ff;
      size_in     = size_ff;
      st_in       = st_ff;
      sz_in       = sz_ff;
      ridx_in     = ridx_ff;
      pa_in       = pa_ff;
      hit_in      = hit_ff;
      has_next_in = has_next_ff;
      nxt_in      = nxt_ff;
      prv_in      = prv_ff;
      ga_in       = ga_ff;
      gs_in       = gs_ff;
      status_in   = status_ff;
      paddr_in    = paddr_ff;
      gsize_in    = gsize_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_raddr   = '0;

      need      = grow_need(size_ff);
      have_need = {1'b0, size_ff} + 34'(HEADER_BYTES + MIN_PAYLOAD_BYTES);
      nx_end    = {2'b0, st_ff} + 34'(HEADER_BYTES) + {2'b0, sz_ff};
      nx_sum    = {2'b0, sz_ff} + 34'(HEADER_BYTES) + {2'b0, nxt_ff.size};
      with_next = has_next_ff && (nx_end == {2'b0, nxt_ff.start}) && (nx_sum[33:32] == 2'b0);
      nsz       = with_next ? nx_sum : {2'b0, sz_ff};
      pv_end    = {2'b0, prv_ff.start} + 34'(HEADER_BYTES) + {2'b0, prv_ff.size};
      pv_sum    = {2'b0, prv_ff.size} + 34'(HEADER_BYTES) + nsz;
      with_prev = (hit_ff != '0) && (pv_end == {2'b0, st_ff}) && (pv_sum[33:32] == 2'b0);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pv_in   = 1'b0;
               ridx_in = '0;
               if (func_type'(req_func) == FUNC_ALLOC) begin
                  if (req_size == '0) begin
                     strobe_in = 1'b1;
                     status_in = STAT_IGNORED;
                     paddr_in  = '0;
                     gsize_in  = '0;
                  end else begin
                     alloc_in = 1'b1;
                     retry_in = 1'b0;
                     put_in   = 1'b0;
                     size_in  = round_size(req_size);
                     state_in = ST_TAKE;
                  end
               end else begin
                  if (req_block_addr == '0 || req_block_size == '0) begin
                     strobe_in = 1'b1;
                     status_in = STAT_IGNORED;
                     paddr_in  = '0;
                     gsize_in  = '0;
                  end else begin
                     alloc_in    = 1'b0;
                     put_in      = 1'b1;
                     st_in       = req_block_addr - 32'(HEADER_BYTES);
                     sz_in       = req_block_size;
                     has_next_in = 1'b0;
                     state_in    = ST_PSCAN;
                  end
               end
            end
         end

         ST_TAKE: begin
            if (pv_ff && ({1'b0, mem_rdata.size} >= size_ff)) begin
               ga_in = mem_rdata.start + 32'(HEADER_BYTES);
               pv_in = 1'b0;
               if ({2'b0, mem_rdata.size} >= have_need) begin
                  mem_we          = 1'b1;
                  mem_waddr       = pa_ff[IW-1:0];
                  mem_wdata.start = mem_rdata.start + 32'(HEADER_BYTES) + size_ff[31:0];
                  mem_wdata.size  = mem_rdata.size - size_ff[31:0] - 32'(HEADER_BYTES);
                  strobe_in       = 1'b1;
                  status_in       = STAT_OK;
                  paddr_in        = mem_rdata.start + 32'(HEADER_BYTES);
                  gsize_in        = size_ff[31:0];
                  state_in        = ST_IDLE;
               end else begin
                  gs_in    = mem_rdata.size;
                  ridx_in  = pa_ff + CW'(1);
                  put_in   = 1'b0;
                  state_in = ST_DROP;
               end
            end else if (ridx_ff < cnt_ff) begin
               mem_raddr = ridx_ff[IW-1:0];
               pv_in     = 1'b1;
               pa_in     = ridx_ff;
               ridx_in   = ridx_ff + CW'(1);
            end else if (!pv_ff) begin
               if (retry_ff) begin
                  strobe_in = 1'b1;
                  status_in = STAT_OOM;
                  paddr_in  = '0;
                  gsize_in  = '0;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_GROW;
               end
            end else begin
               pv_in = 1'b0;
            end
         end

         ST_DROP: begin
            // shift the tail down by one entry
            if (pv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = IW'(pa_ff - CW'(1));
               mem_wdata = mem_rdata;
            end
            if (ridx_ff < cnt_ff) begin
               mem_raddr = ridx_ff[IW-1:0];
               pv_in     = 1'b1;
               pa_in     = ridx_ff;
               ridx_in   = ridx_ff + CW'(1);
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) begin
                  cnt_in = cnt_ff - CW'(1);
                  if (put_ff) begin
                     if (alloc_ff) begin
                        used_in  = used_ff + need[31:0];
                        retry_in = 1'b1;
                        put_in   = 1'b0;
                        ridx_in  = '0;
                        state_in = ST_TAKE;
                     end else begin
                        strobe_in = 1'b1;
                        status_in = STAT_OK;
                        paddr_in  = '0;
                        gsize_in  = '0;
                        state_in  = ST_IDLE;
                     end
                  end else begin
                     strobe_in = 1'b1;
                     status_in = STAT_OK;
                     paddr_in  = ga_ff;
                     gsize_in  = gs_ff;
                     state_in  = ST_IDLE;
                  end
               end
            end
         end

         ST_GROW: begin
            if ({2'b0, used_ff} + need > {2'b0, heap_limit}) begin
               strobe_in = 1'b1;
               status_in = STAT_OOM;
               paddr_in  = '0;
               gsize_in  = '0;
               state_in  = ST_IDLE;
            end else begin
               st_in       = heap_base + used_ff;
               sz_in       = 32'(need - 34'(HEADER_BYTES));
               put_in      = 1'b1;
               has_next_in = 1'b0;
               ridx_in     = '0;
               pv_in       = 1'b0;
               state_in    = ST_PSCAN;
            end
         end

         ST_PSCAN: begin
            if (pv_ff && (mem_rdata.start >= st_ff)) begin
               hit_in      = pa_ff;
               nxt_in      = mem_rdata;
               has_next_in = 1'b1;
               pv_in       = 1'b0;
               state_in    = ST_PDECIDE;
            end else begin
               if (pv_ff) begin
                  prv_in = mem_rdata;
               end
               if (ridx_ff < cnt_ff) begin
                  mem_raddr = ridx_ff[IW-1:0];
                  pv_in     = 1'b1;
                  pa_in     = ridx_ff;
                  ridx_in   = ridx_ff + CW'(1);
               end else begin
                  pv_in = 1'b0;
                  if (!pv_ff) begin
                     hit_in      = cnt_ff;
                     has_next_in = 1'b0;
                     state_in    = ST_PDECIDE;
                  end
               end
            end
         end

         ST_PDECIDE: begin
            pv_in = 1'b0;
            if (with_prev) begin
               mem_we          = 1'b1;
               mem_waddr       = IW'(hit_ff - CW'(1));
               mem_wdata.start = prv_ff.start;
               mem_wdata.size  = pv_sum[31:0];
               if (with_next) begin
                  ridx_in  = hit_ff + CW'(1);
                  state_in = ST_DROP;
               end
            end else if (with_next) begin
               mem_we          = 1'b1;
               mem_waddr       = hit_ff[IW-1:0];
               mem_wdata.start = st_ff;
               mem_wdata.size  = nsz[31:0];
            end else if (cnt_ff >= CW'(MAX_EXTENTS)) begin
               strobe_in = 1'b1;
               status_in = STAT_FULL;
               paddr_in  = '0;
               gsize_in  = '0;
               state_in  = ST_IDLE;
            end else begin
               ridx_in  = cnt_ff;
               state_in = ST_SHIFTUP;
            end
            // merged in place: the put is complete
            if (with_prev ? !with_next : with_next) begin
               if (alloc_ff) begin
                  used_in  = used_ff + need[31:0];
                  retry_in = 1'b1;
                  put_in   = 1'b0;
                  ridx_in  = '0;
                  state_in = ST_TAKE;
               end else begin
                  strobe_in = 1'b1;
                  status_in = STAT_OK;
                  paddr_in  = '0;
                  gsize_in  = '0;
                  state_in  = ST_IDLE;
               end
            end
         end

         ST_SHIFTUP: begin
            // ridx_ff is one above the next entry to move up
            if (pv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = IW'(pa_ff + CW'(1));
               mem_wdata = mem_rdata;
            end
            if (ridx_ff > hit_ff) begin
               mem_raddr = IW'(ridx_ff - CW'(1));
               pv_in     = 1'b1;
               pa_in     = ridx_ff - CW'(1);
               ridx_in   = ridx_ff - CW'(1);
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) begin
                  mem_we          = 1'b1;
                  mem_waddr       = hit_ff[IW-1:0];
                  mem_wdata.start = st_ff;
                  mem_wdata.size  = sz_ff;
                  cnt_in          = cnt_ff + CW'(1);
                  if (alloc_ff) begin
                     used_in  = used_ff + need[31:0];
                     retry_in = 1'b1;
                     put_in   = 1'b0;
                     ridx_in  = '0;
                     state_in = ST_TAKE;
                  end else begin
                     strobe_in = 1'b1;
                     status_in = STAT_OK;
                     paddr_in  = '0;
                     gsize_in  = '0;
                     state_in  = ST_IDLE;
                  end
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_payload_addr = paddr_ff;
   assign rsp_granted_size = gsize_ff;

endmodule
